[hw/rtl/sync_mailbox_table_unit_defines.svh]
// Assertion macros shared by the mailbox table RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef SYNC_MAILBOX_TABLE_UNIT_DEFINES_SVH
`define SYNC_MAILBOX_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SMT_ASSERT_NOW(label, clk_sig, rst_n_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!(rst_n_sig)) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SMT_ASSERT_NEXT(label, clk_sig, rst_n_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!(rst_n_sig)) \
        (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/smt_pkg.sv]
// Shared types and constants for the mailbox table unit.
// Depends on nothing; imported by the top level.
package smt_pkg;

    localparam int ID_W  = 32;
    localparam int VAL_W = 32;
    localparam int REQ_W = 2;

    typedef logic [ID_W-1:0]  id_t;
    typedef logic [VAL_W-1:0] val_t;

    typedef enum logic [REQ_W-1:0] {
        REQ_SEND   = 2'd0,
        REQ_CLEAR  = 2'd1,
        REQ_LOOKUP = 2'd2
    } req_type_t;

    typedef struct packed {
        logic found;
        logic send_dropped;
        val_t value_out;
    } result_t;

endpackage

[hw/rtl/sync_mailbox_table_unit.sv]
// Mailbox table unit: slot table with send, clear and lookup requests.
// Depends on smt_pkg and sync_mailbox_table_unit_defines.svh.
//
// Usage:
//   Input words arrive on the s_axis group. tuser carries the request kind
//   (send, clear, lookup); tdata carries the target id and the send value.
//   Every accepted word yields exactly one result word on the m_axis group:
//   tdata holds the looked-up value, tuser holds the found and dropped flags.
//   A word is first held in an input register; from there the whole table
//   is compared in parallel, the lowest free or matching slot is picked by
//   a priority encoder, the table is updated and the result is written to
//   the output register. One word is taken per cycle while the receiver
//   keeps up, the parallel compare over all slots being the only work on
//   the path.
//   When the receiver stalls, the result holds in the output register while
//   one more word may still enter the input register; after that tready
//   drops until the result is taken.
//   Reset frees every slot at once (owner flip-flops clear) and empties both
//   registers. Slot values are not cleared; only written slots are ever read.
`include "sync_mailbox_table_unit_defines.svh"

module sync_mailbox_table_unit
    import smt_pkg::*;
#(
    parameter int SLOT_COUNT = 16
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] target_id, [63:32] sync_value
    input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] value_out
    output logic [1:0]  m_axis_tuser    // [0] found, [1] send_dropped
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    // Input register
    logic             in_valid_reg;
    logic [REQ_W-1:0] in_req_reg;
    id_t              in_id_reg;
    val_t             in_val_reg;

    // Output register
    logic             out_valid_reg;
    logic             out_found_reg;
    logic             out_dropped_reg;
    val_t             out_value_reg;

    // Slot table: owners in flip-flops, values in a memory
    id_t              owner_reg [SLOT_COUNT];
    val_t             value_mem [SLOT_COUNT];

    logic             advance;
    logic             in_take;
    logic             free_any;
    logic [IDX_W-1:0] free_idx;
    logic             hit_any;
    logic [IDX_W-1:0] hit_idx;
    logic             do_send;
    logic             do_clear;
    logic             do_lookup;
    result_t          res_next;

    // Process the held word when the result slot is empty or being drained
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    // Lowest free slot and lowest slot owned by the held id
    always_comb
    begin
        free_any = 1'b0;
        free_idx = '0;
        hit_any  = 1'b0;
        hit_idx  = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (owner_reg[i] == '0)
            begin
                free_any = 1'b1;
                free_idx = IDX_W'(i);
            end
            if (owner_reg[i] == in_id_reg)
            begin
                hit_any = 1'b1;
                hit_idx = IDX_W'(i);
            end
        end
    end

    // Decode the request; id zero makes send and lookup no-ops, code three idles
    always_comb
    begin
        do_send   = 1'b0;
        do_clear  = 1'b0;
        do_lookup = 1'b0;
        case (in_req_reg)
            REQ_SEND:   do_send   = (in_id_reg != '0);
            REQ_CLEAR:  do_clear  = 1'b1;
            REQ_LOOKUP: do_lookup = (in_id_reg != '0);
            default:    ;
        endcase
        res_next.found        = do_lookup && hit_any;
        res_next.send_dropped = do_send && !free_any;
        res_next.value_out    = '0;
    end

    // Input register: accept whenever the held word moves on or none is held
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_req_reg <= s_axis_tuser;
            in_id_reg  <= s_axis_tdata[31:0];
            in_val_reg <= s_axis_tdata[63:32];
        end
    end

    // Owner table: claim the lowest free slot on send, free matches on clear
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                owner_reg[i] <= '0;
            end
        end
        else if (advance)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                if (do_send && free_any && (free_idx == IDX_W'(i)))
                begin
                    owner_reg[i] <= in_id_reg;
                end
                else if (do_clear && (owner_reg[i] == in_id_reg))
                begin
                    owner_reg[i] <= '0;
                end
            end
        end
    end

    // Value memory: write on a placed send, registered read into the result
    always_ff @(posedge clk)
    begin
        if (advance && do_send && free_any)
        begin
            value_mem[free_idx] <= in_val_reg;
        end
        if (advance)
        begin
            out_found_reg   <= res_next.found;
            out_dropped_reg <= res_next.send_dropped;
            out_value_reg   <= res_next.found ? value_mem[hit_idx] : res_next.value_out;
        end
    end

    // Output valid: set on a processed word, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_value_reg;
    assign m_axis_tuser  = {out_dropped_reg, out_found_reg};

    `SMT_ASSERT_NOW(a_flags_exclusive, clk, rst_n, m_axis_tvalid,
        !(m_axis_tuser[0] && m_axis_tuser[1]), "found and send_dropped both set")
    `SMT_ASSERT_NOW(a_value_zero_on_miss, clk, rst_n, m_axis_tvalid && !m_axis_tuser[0],
        m_axis_tdata == '0, "value_out nonzero without a lookup hit")
    `SMT_ASSERT_NOW(a_stall_only_when_full, clk, rst_n, !s_axis_tready,
        in_valid_reg && m_axis_tvalid && !m_axis_tready, "input stalled without backpressure")
    `SMT_ASSERT_NEXT(a_advance_gives_result, clk, rst_n, advance,
        m_axis_tvalid, "processed word produced no result")

endmodule
